/* hw/rtl/ctcg_pkg.sv */
// ctcg_pkg: shared types, widths and constants of the ctc greedy decoder
// no dependencies; imported by the channel interfaces and every rtl module
`default_nettype none

package ctcg_pkg;

   // field widths of the item and result channels
   localparam int PROB_W  = 16;
   localparam int LABEL_W = 8;
   localparam int COUNT_W = 9;
   localparam int SCORE_W = 32;

   // defaults of the top level parameters
   localparam int DEF_MAX_CLASSES = 256;
   localparam int DEF_PROB_BITS   = 16;

   // class count register
   localparam logic [COUNT_W-1:0] CLASS_COUNT_RESET = 9'd29;
   localparam int  CSR_ADDR_W  = 3;
   localparam int  CSR_DATA_W  = 32;
   localparam logic CSR_IDX_CLASS_COUNT = 1'b0;

   // log unit: q1.31 mantissa, one fraction bit per squaring stage
   localparam int Y_W      = 32;
   localparam int FRAC_W   = 16;
   localparam int SQ_STEPS = 16;
   localparam int MSB_W    = $clog2(PROB_W);
   localparam int INT_W    = 6;
   localparam int WHOLE_W  = INT_W + FRAC_W;
   localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

   // timestep record from the argmax front end
   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               label_valid;
      logic               last;
      logic [PROB_W-1:0]  prob;
   } ctcg_rec_type;

   // timestep record with its -ln(max) in q16.16
   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               label_valid;
      logic               last;
      logic [SCORE_W-1:0] neg_ln;
   } ctcg_scored_type;

endpackage

`default_nettype wire

/* hw/rtl/ctcg_if.sv */
// ctcg_req_if, ctcg_rsp_if: valid/ready channels for probability items and results
// depends on ctcg_pkg for the field widths
`default_nettype none

interface ctcg_req_if
   import ctcg_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [PROB_W-1:0] prob;
   logic              last_of_sequence;

   modport source (output valid, output prob, output last_of_sequence, input ready);
   modport sink (input valid, input prob, input last_of_sequence, output ready);
endinterface

interface ctcg_rsp_if
   import ctcg_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [LABEL_W-1:0] label;
   logic               label_valid;
   logic [SCORE_W-1:0] neg_log_score;
   logic               sequence_done;

   modport source (output valid, output label, output label_valid,
                   output neg_log_score, output sequence_done, input ready);
   modport sink (input valid, input label, input label_valid,
                 input neg_log_score, input sequence_done, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ctcg_csr.sv */
// ctcg_csr: apb-style register port holding the class count
// depends on ctcg_pkg
`default_nettype none

module ctcg_csr
   import ctcg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [COUNT_W-1:0]    class_count
);

   logic [COUNT_W-1:0] class_count_ff;
   logic [COUNT_W-1:0] class_count_in;
   logic               reg_index;

   assign reg_index = paddr[2];
   assign pready    = 1'b1;

   // write decode, other register indexes are ignored
   always_comb begin
      class_count_in = class_count_ff;
      if (psel && penable && pwrite && (reg_index == CSR_IDX_CLASS_COUNT)) begin
         class_count_in = pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff <= CLASS_COUNT_RESET;
      end else begin
         class_count_ff <= class_count_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (reg_index == CSR_IDX_CLASS_COUNT) begin
         prdata = {{(CSR_DATA_W-COUNT_W){1'b0}}, class_count_ff};
      end
   end

   assign class_count = class_count_ff;

endmodule

`default_nettype wire

/* hw/rtl/ctcg_front.sv */
// ctcg_front: input register, running argmax per timestep and label decision
// depends on ctcg_pkg and ctcg_req_if; feeds timestep records to ctcg_neglog
`default_nettype none

module ctcg_front
   import ctcg_pkg::*;
#(
   parameter int MAX_CLASSES = DEF_MAX_CLASSES,
   parameter int PROB_BITS   = DEF_PROB_BITS
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   ctcg_req_if.sink                req_ch,
   input  wire logic [COUNT_W-1:0] class_count,
   input  wire logic               pipe_en,
   output logic                    rec_valid,
   output ctcg_rec_type            rec
);

   localparam logic [31:0] PMAX = 32'((64'd1 << PROB_BITS) - 64'd1);

   // input register
   logic                a_valid_ff, a_valid_in;
   logic [PROB_W-1:0]   a_prob_ff;
   logic                a_last_ff;

   // timestep state
   logic [LABEL_W-1:0]  pos_ff, pos_in;
   logic [PROB_W-1:0]   best_prob_ff, best_prob_in;
   logic [LABEL_W-1:0]  best_idx_ff, best_idx_in;
   logic [LABEL_W-1:0]  prev_label_ff, prev_label_in;
   logic                prev_valid_ff, prev_valid_in;

   // record register
   logic                rec_valid_ff, rec_valid_in;
   ctcg_rec_type        rec_ff, rec_in;

   logic [COUNT_W-1:0]  count_eff;
   logic [PROB_W-1:0]   p_sat;
   logic [PROB_W-1:0]   nb_prob;
   logic [LABEL_W-1:0]  nb_idx;
   logic                step_end;
   logic                lbl_valid;
   logic                a_advance;
   logic                a_take;
   logic                req_take;

   // class count clamped to the supported range
   always_comb begin
      count_eff = class_count;
      if (class_count < COUNT_W'(2)) begin
         count_eff = COUNT_W'(2);
      end else if (class_count > COUNT_W'(MAX_CLASSES)) begin
         count_eff = COUNT_W'(MAX_CLASSES);
      end
   end

   // saturate probability and track the running maximum, first class wins a tie
   always_comb begin
      p_sat = a_prob_ff;
      if ({16'b0, a_prob_ff} > PMAX) begin
         p_sat = PMAX[PROB_W-1:0];
      end
      nb_prob = best_prob_ff;
      nb_idx  = best_idx_ff;
      if ((pos_ff == '0) || (p_sat > best_prob_ff)) begin
         nb_prob = p_sat;
         nb_idx  = pos_ff;
      end
   end

   assign step_end  = a_last_ff || ({1'b0, pos_ff} >= (count_eff - COUNT_W'(1)));
   assign lbl_valid = (!prev_valid_ff || (nb_idx != prev_label_ff))
                      && ({1'b0, nb_idx} != (count_eff - COUNT_W'(1)));

   // a timestep end needs a free slot in the log pipeline
   assign a_advance    = !step_end || pipe_en;
   assign a_take       = a_valid_ff && a_advance;
   assign req_ch.ready = !a_valid_ff || a_advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   // next state
   always_comb begin
      a_valid_in    = a_valid_ff;
      pos_in        = pos_ff;
      best_prob_in  = best_prob_ff;
      best_idx_in   = best_idx_ff;
      prev_label_in = prev_label_ff;
      prev_valid_in = prev_valid_ff;
      rec_valid_in  = rec_valid_ff;
      rec_in        = rec_ff;
      if (a_take) begin
         a_valid_in = 1'b0;
      end
      if (req_take) begin
         a_valid_in = 1'b1;
      end
      if (a_take && !step_end) begin
         pos_in       = pos_ff + LABEL_W'(1);
         best_prob_in = nb_prob;
         best_idx_in  = nb_idx;
      end else if (a_take) begin
         pos_in        = '0;
         best_prob_in  = '0;
         best_idx_in   = '0;
         prev_label_in = a_last_ff ? '0 : nb_idx;
         prev_valid_in = !a_last_ff;
      end
      if (pipe_en) begin
         rec_valid_in = a_take && step_end;
         if (a_take && step_end) begin
            rec_in.label       = lbl_valid ? nb_idx : '0;
            rec_in.label_valid = lbl_valid;
            rec_in.last        = a_last_ff;
            rec_in.prob        = nb_prob;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         pos_ff        <= '0;
         best_prob_ff  <= '0;
         best_idx_ff   <= '0;
         prev_label_ff <= '0;
         prev_valid_ff <= 1'b0;
         rec_valid_ff  <= 1'b0;
      end else begin
         a_valid_ff    <= a_valid_in;
         pos_ff        <= pos_in;
         best_prob_ff  <= best_prob_in;
         best_idx_ff   <= best_idx_in;
         prev_label_ff <= prev_label_in;
         prev_valid_ff <= prev_valid_in;
         rec_valid_ff  <= rec_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         a_prob_ff <= req_ch.prob;
         a_last_ff <= req_ch.last_of_sequence;
      end
      rec_ff <= rec_in;
   end

   assign rec_valid = rec_valid_ff;
   assign rec       = rec_ff;

endmodule

`default_nettype wire

/* hw/rtl/ctcg_neglog.sv */
// ctcg_neglog: pipelined -ln(p) in q16.16, one squaring per stage
// depends on ctcg_pkg; takes records from ctcg_front, feeds ctcg_score
`default_nettype none

module ctcg_neglog
   import ctcg_pkg::*;
#(
   parameter int PROB_BITS = DEF_PROB_BITS
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            pipe_en,
   input  wire logic            in_valid,
   input  wire ctcg_rec_type    in_rec,
   output logic                 out_valid,
   output ctcg_scored_type      out_rec
);

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               label_valid;
      logic               last;
      logic [Y_W-1:0]     y;
      logic [FRAC_W-1:0]  frac;
      logic [INT_W-1:0]   ip;
   } lg_stage_type;

   lg_stage_type        st_ff [0:SQ_STEPS];
   lg_stage_type        st0_in;
   lg_stage_type        st_in [1:SQ_STEPS];
   logic [SQ_STEPS:0]   v_ff;
   logic                nl_valid_ff;
   ctcg_scored_type     nl_ff, nl_in;

   logic [PROB_W-1:0]   p1;
   logic [MSB_W-1:0]    msb;
   logic [WHOLE_W-1:0]  whole;
   logic [WHOLE_W+Y_W-1:0] prod;

   // index of the top set bit
   function automatic logic [MSB_W-1:0] top_bit(input logic [PROB_W-1:0] v);
      logic [MSB_W-1:0] r;
      r = '0;
      for (int i = 0; i < PROB_W; i++) begin
         if (v[i]) begin
            r = MSB_W'(i);
         end
      end
      return r;
   endfunction

   // normalise to q1.31, zero is taken as the smallest code
   always_comb begin
      p1  = (in_rec.prob == '0) ? PROB_W'(1) : in_rec.prob;
      msb = top_bit(p1);
      st0_in.label       = in_rec.label;
      st0_in.label_valid = in_rec.label_valid;
      st0_in.last        = in_rec.last;
      st0_in.y           = {{(Y_W-PROB_W){1'b0}}, p1} << (5'd31 - 5'(msb));
      st0_in.frac        = '0;
      st0_in.ip          = INT_W'(PROB_BITS - int'(msb));
   end

   // squaring stages: each yields one bit of log2 of the mantissa
   always_comb begin
      logic [2*Y_W-1:0] sq;
      logic [Y_W:0]     t;
      for (int k = 1; k <= SQ_STEPS; k++) begin
         sq = st_ff[k-1].y * st_ff[k-1].y;
         t  = sq[2*Y_W-1:Y_W-1];
         st_in[k]      = st_ff[k-1];
         st_in[k].y    = t[Y_W] ? t[Y_W:1] : t[Y_W-1:0];
         st_in[k].frac = {st_ff[k-1].frac[FRAC_W-2:0], t[Y_W]};
      end
   end

   // -log2 to -ln by multiplying with ln 2, rounded
   always_comb begin
      whole = {st_ff[SQ_STEPS].ip, {FRAC_W{1'b0}}}
              - {{INT_W{1'b0}}, st_ff[SQ_STEPS].frac};
      prod  = (whole * LN2_Q32) + (WHOLE_W+Y_W)'(64'h8000_0000);
      nl_in.label       = st_ff[SQ_STEPS].label;
      nl_in.label_valid = st_ff[SQ_STEPS].label_valid;
      nl_in.last        = st_ff[SQ_STEPS].last;
      nl_in.neg_ln      = {{(SCORE_W-WHOLE_W){1'b0}}, prod[WHOLE_W+Y_W-1:Y_W]};
   end

   // stage valid bits move in lockstep
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff        <= '0;
         nl_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         v_ff        <= {v_ff[SQ_STEPS-1:0], in_valid};
         nl_valid_ff <= v_ff[SQ_STEPS];
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         st_ff[0] <= st0_in;
         for (int k = 1; k <= SQ_STEPS; k++) begin
            st_ff[k] <= st_in[k];
         end
         nl_ff <= nl_in;
      end
   end

   assign out_valid = nl_valid_ff;
   assign out_rec   = nl_ff;

endmodule

`default_nettype wire

/* hw/rtl/ctcg_score.sv */
// ctcg_score: saturating score accumulator and result register
// depends on ctcg_pkg and ctcg_rsp_if; takes records from ctcg_neglog
`default_nettype none

module ctcg_score
   import ctcg_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             nl_valid,
   input  wire ctcg_scored_type  nl,
   output logic                  pipe_en,
   ctcg_rsp_if.source            rsp_ch
);

   logic [SCORE_W-1:0]  score_ff, score_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LABEL_W-1:0]  label_ff;
   logic                label_valid_ff;
   logic [SCORE_W-1:0]  nls_ff;
   logic                done_ff;

   logic [SCORE_W:0]    sum;
   logic [SCORE_W-1:0]  sat;
   logic                emit;
   logic                out_free;
   logic                go;

   // saturating add of this timestep's -ln(max)
   assign sum = {1'b0, score_ff} + {1'b0, nl.neg_ln};
   assign sat = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];

   // a record without a result never waits on the result register
   assign emit     = nl.label_valid || nl.last;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign go       = nl_valid && (!emit || out_free);
   assign pipe_en  = !nl_valid || go;

   always_comb begin
      score_in     = score_ff;
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         score_in = nl.last ? '0 : sat;
      end
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (go && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         score_ff     <= score_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (go && emit) begin
         label_ff       <= nl.label;
         label_valid_ff <= nl.label_valid;
         nls_ff         <= nl.last ? sat : '0;
         done_ff        <= nl.last;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.label         = label_ff;
   assign rsp_ch.label_valid   = label_valid_ff;
   assign rsp_ch.neg_log_score = nls_ff;
   assign rsp_ch.sequence_done = done_ff;

endmodule

`default_nettype wire

/* hw/rtl/ctcg_greedy_decoder_core.sv */
// ctc greedy decoder: one probability item per cycle, back to back
// path: once the item closing its timestep is accepted, its result passes the record
// register, 17 log stages, the ln 2 multiply and the result register
// throughput: one item per cycle; a timestep end stalls the input while the log
// pipeline output needs the result register and the last result is not yet taken
// reset: synchronous, clears all timestep and score state, class count to 29
`default_nettype none

module ctc_greedy_decoder_core
   import ctcg_pkg::*;
#(
   parameter int MAX_CLASSES = DEF_MAX_CLASSES,
   parameter int PROB_BITS   = DEF_PROB_BITS
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   ctcg_req_if.sink                   req_ch,
   ctcg_rsp_if.source                 rsp_ch,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic [COUNT_W-1:0] class_count;
   logic               pipe_en;
   logic               rec_valid;
   ctcg_rec_type       rec;
   logic               nl_valid;
   ctcg_scored_type    nl;

   // register port
   ctcg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .class_count (class_count)
   );

   // argmax and label decision
   ctcg_front #(
      .MAX_CLASSES (MAX_CLASSES),
      .PROB_BITS   (PROB_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .class_count (class_count),
      .pipe_en     (pipe_en),
      .rec_valid   (rec_valid),
      .rec         (rec)
   );

   // -ln of the timestep maximum
   ctcg_neglog #(
      .PROB_BITS (PROB_BITS)
   ) u_neglog (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (rec_valid),
      .in_rec    (rec),
      .out_valid (nl_valid),
      .out_rec   (nl)
   );

   // score and result register
   ctcg_score u_score (
      .clock    (clock),
      .reset    (reset),
      .nl_valid (nl_valid),
      .nl       (nl),
      .pipe_en  (pipe_en),
      .rsp_ch   (rsp_ch)
   );

   // every result carries a label or closes a sequence
   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.label_valid || rsp_ch.sequence_done))
      else $error("result with neither label nor sequence end");

   // fields without meaning read as zero
   a_label_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.label_valid) |-> (rsp_ch.label == '0))
      else $error("label not zero without label_valid");

   a_score_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.sequence_done) |-> (rsp_ch.neg_log_score == '0))
      else $error("score not zero before sequence end");

   // the log pipeline only stalls behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |-> (rsp_ch.valid && !rsp_ch.ready))
      else $error("pipeline stalled with a free result register");

endmodule

`default_nettype wire

/* tb/ctc_greedy_decoder_core_test.sv */
// ctc_greedy_decoder_core_test: self-checking bench for the streaming ctc greedy decoder
// depends on ctcg_pkg, the ctcg_req_if / ctcg_rsp_if channels and ctc_greedy_decoder_core
// drives probability items and apb writes, predicts labels and -ln scores, checks results
`default_nettype none

module ctc_greedy_decoder_core_test;
   import ctcg_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int UNMAPPED_IDX = 1;

   // one decoded result as it leaves the block
   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               label_valid;
      logic [SCORE_W-1:0] neg_log_score;
      logic               sequence_done;
   } decode_result_type;

   // best-path predictor and store of expected results
   class ctc_decode_scoreboard;
      logic [COUNT_W-1:0] class_count;
      logic [LABEL_W-1:0] class_pos;
      logic [PROB_W-1:0]  best_prob;
      logic [LABEL_W-1:0] best_idx;
      logic [LABEL_W-1:0] prev_label;
      bit                 prev_seen;
      logic [SCORE_W-1:0] score_sum;
      decode_result_type  expected_q[$];
      int                 fails;

      function new();
         class_count = CLASS_COUNT_RESET;
         fails = 0;
         clear_sequence();
      endfunction

      function void clear_sequence();
         class_pos  = '0;
         best_prob  = '0;
         best_idx   = '0;
         prev_label = '0;
         prev_seen  = 0;
         score_sum  = '0;
      endfunction

      task report(string what);
         fails++;
         $display("mismatch: %s", what);
      endtask

      function void write_reg(int idx, logic [CSR_DATA_W-1:0] value);
         if (idx == int'(CSR_IDX_CLASS_COUNT)) class_count = value[COUNT_W-1:0];
      endfunction

      // classes per timestep after clamping to the legal range
      function int effective_count();
         int cnt;
         cnt = int'(class_count);
         if (cnt < 2) cnt = 2;
         if (cnt > DEF_MAX_CLASSES) cnt = DEF_MAX_CLASSES;
         return cnt;
      endfunction

      // -ln(p) in q16.16 via log2 by repeated squaring, then times ln 2
      function logic [31:0] neg_ln_q16(logic [PROB_W-1:0] prob);
         logic [PROB_W-1:0] p;
         int                msb;
         logic [63:0]       y;
         logic [15:0]       frac;
         logic [63:0]       whole;
         p = (prob == '0) ? 16'd1 : prob;
         msb = 0;
         for (int b = 0; b < PROB_W; b++)
            if (p[b]) msb = b;
         y = 64'(p) << (31 - msb);
         frac = '0;
         for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= 64'h1_0000_0000) begin
               frac[0] = 1'b1;
               y = y >> 1;
            end
         end
         whole = (64'(DEF_PROB_BITS - msb) << 16) - 64'(frac);
         return 32'((whole * 64'(LN2_Q32) + 64'h8000_0000) >> 32);
      endfunction

      // one accepted probability item
      function void note_item(logic [PROB_W-1:0] prob, bit is_last);
         int                cnt;
         bit                step_end;
         bit                fresh;
         logic [32:0]       sum;
         decode_result_type res;
         cnt = effective_count();
         if (class_pos == '0 || prob > best_prob) begin
            best_prob = prob;
            best_idx  = class_pos;
         end
         step_end = is_last || int'(class_pos) >= cnt - 1;
         if (!step_end) begin
            class_pos = class_pos + 1'b1;
            return;
         end
         fresh = (!prev_seen || best_idx != prev_label) && int'(best_idx) != cnt - 1;
         prev_label = best_idx;
         prev_seen  = 1;
         sum = 33'(score_sum) + 33'(neg_ln_q16(best_prob));
         score_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         res.label         = fresh ? best_idx : '0;
         res.label_valid   = fresh;
         res.neg_log_score = is_last ? score_sum : '0;
         res.sequence_done = is_last;
         class_pos = '0;
         best_prob = '0;
         best_idx  = '0;
         if (fresh || is_last) expected_q.push_back(res);
         if (is_last) clear_sequence();
      endfunction

      // one accepted result against the oldest expectation
      task check_result(decode_result_type got);
         decode_result_type exp_res;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result label %0d/%0b score %h done %0b",
                             got.label, got.label_valid, got.neg_log_score,
                             got.sequence_done));
            return;
         end
         exp_res = expected_q.pop_front();
         if (got.label !== exp_res.label)
            report($sformatf("label %0d, expected %0d", got.label, exp_res.label));
         if (got.label_valid !== exp_res.label_valid)
            report($sformatf("label_valid %0b, expected %0b", got.label_valid,
                             exp_res.label_valid));
         if (got.neg_log_score !== exp_res.neg_log_score)
            report($sformatf("neg_log_score %h, expected %h", got.neg_log_score,
                             exp_res.neg_log_score));
         if (got.sequence_done !== exp_res.sequence_done)
            report($sformatf("sequence_done %0b, expected %0b", got.sequence_done,
                             exp_res.sequence_done));
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ctcg_req_if req_ch ();
   ctcg_rsp_if rsp_ch ();

   ctc_decode_scoreboard sb;
   bit steady_mode   = 0;
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int cycle_count   = 0;

   ctc_greedy_decoder_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: check accepted items, then choose next ready
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         sb.check_result('{rsp_ch.label, rsp_ch.label_valid, rsp_ch.neg_log_score,
                           rsp_ch.sequence_done});
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady_mode || ($urandom_range(99) >= 25);
      end
   end

   // offer one item and wait until it is taken
   task automatic send_item(logic [PROB_W-1:0] prob, bit is_last);
      if (!steady_mode && $urandom_range(99) < 25) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.prob             <= prob;
      req_ch.last_of_sequence <= is_last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_item(prob, is_last);
   endtask

   // stop offering and wait for every expected result
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle then access cycle
   task automatic csr_write(int idx, logic [CSR_DATA_W-1:0] value);
      drain_results();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * idx);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   // class count with random bits above the register field
   function automatic logic [CSR_DATA_W-1:0] count_word(int value);
      return ($urandom & ~32'h1FF) | 32'(value & 32'h1FF);
   endfunction

   // mix of extremes, ties and random probabilities
   function automatic logic [PROB_W-1:0] pick_prob(logic [PROB_W-1:0] prev);
      int roll;
      roll = $urandom_range(99);
      if (roll < 15) return '0;
      if (roll < 25) return '1;
      if (roll < 40) return prev;
      if (roll < 55) return PROB_W'($urandom_range(1, 255));
      return PROB_W'($urandom);
   endfunction

   // well-formed sequences with random content, some cut short
   task automatic run_random(int n_items, int max_steps, int early_pct, bit pause);
      int sent;
      int n_steps;
      int len;
      bit early;
      bit paused;
      bit is_last;
      logic [PROB_W-1:0] prob;
      sent = 0;
      paused = 0;
      prob = '0;
      while (sent < n_items) begin
         n_steps = $urandom_range(1, max_steps);
         early = $urandom_range(99) < early_pct;
         for (int ts = 0; ts < n_steps; ts++) begin
            len = sb.effective_count();
            if (ts == n_steps - 1 && early)
               len = $urandom_range(1, (len < 40) ? len : 40);
            for (int k = 0; k < len; k++) begin
               is_last = (ts == n_steps - 1) && (k == len - 1);
               prob = pick_prob(prob);
               send_item(prob, is_last);
               sent++;
               if (pause && !paused && sent >= n_items / 2) begin
                  drain_results();
                  paused = 1;
               end
            end
         end
      end
   endtask

   task automatic run_phase(int count_value, int n_items, int max_steps, int early_pct,
                            bit steady, bit hold, bit pause);
      csr_write(int'(CSR_IDX_CLASS_COUNT), count_word(count_value));
      steady_mode = steady;
      if (hold) hold_requests++;
      run_random(n_items, max_steps, early_pct, pause);
      steady_mode = 0;
   endtask

   initial begin
      sb = new();
      reset                   <= 1'b1;
      req_ch.valid            <= 1'b0;
      req_ch.prob             <= '0;
      req_ch.last_of_sequence <= 1'b0;
      psel                    <= 1'b0;
      penable                 <= 1'b0;
      pwrite                  <= 1'b0;
      paddr                   <= '0;
      pwdata                  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one-item sequence at the reset class count
      send_item(16'd0, 1'b1);
      csr_write(int'(CSR_IDX_CLASS_COUNT), count_word(3));
      // write to an unmapped register must leave the count alone
      csr_write(UNMAPPED_IDX, 32'd5);
      // zero probabilities, tie on the first class
      send_item(16'd0, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd0, 1'b0);
      // tie at full scale, earlier class wins
      send_item(16'd100, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'hFFFF, 1'b0);
      // same argmax again, no label
      send_item(16'd5, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'd7, 1'b0);
      // blank wins, no label
      send_item(16'd1, 1'b0);
      send_item(16'd2, 1'b0);
      send_item(16'hFFFF, 1'b0);
      // early sequence end after two classes
      send_item(16'd9, 1'b0);
      send_item(16'd40000, 1'b1);
      // full timestep closing the sequence
      send_item(16'h8000, 1'b0);
      send_item(16'h8000, 1'b0);
      send_item(16'd0, 1'b1);
      // count lowered mid-timestep ends it on the next item
      send_item(16'd10, 1'b0);
      send_item(16'd20, 1'b0);
      csr_write(int'(CSR_IDX_CLASS_COUNT), count_word(2));
      send_item(16'd30, 1'b1);

      // random phases over several class counts
      run_phase(0,   30, 6, 15, 0, 0, 0);
      run_phase(1,   30, 6, 15, 0, 0, 0);
      run_phase(2,  100, 6, 15, 1, 0, 0);
      run_phase(3,   60, 5, 15, 0, 1, 0);
      run_phase(5,   50, 4, 15, 0, 0, 1);
      run_phase(7,   40, 4, 20, 0, 0, 0);
      run_phase(29,  40, 2, 30, 0, 0, 0);
      run_phase(256, 256, 1, 0, 0, 0, 0);
      run_phase(511, 20, 1, 100, 0, 0, 0);

      drain_results();
      if (sb.pending() != 0) sb.report($sformatf("%0d results never came", sb.pending()));
      if (sb.fails == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/ctcg_pkg.sv
hw/rtl/ctcg_if.sv
hw/rtl/ctcg_csr.sv
hw/rtl/ctcg_front.sv
hw/rtl/ctcg_neglog.sv
hw/rtl/ctcg_score.sv
hw/rtl/ctcg_greedy_decoder_core.sv
tb/ctc_greedy_decoder_core_test.sv
